// ===== src/nps_pkg.sv =====
`default_nettype none

package nps_pkg;

    // Cloud storage geometry
    localparam int CLOUD_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(CLOUD_DEPTH);

    // Field widths
    localparam int COORD_W = 16;
    localparam int INDEX_W = 10;
    localparam int SIZE_W  = 11;
    localparam int DSQ_W   = 34;
    localparam int ROOT_W  = 17;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } nps_point_t;

    typedef struct packed {
        logic                      op;
        logic        [INDEX_W-1:0] index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } nps_req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] near_x;
        logic signed [COORD_W-1:0] near_y;
        logic signed [COORD_W-1:0] near_z;
        logic        [INDEX_W-1:0] near_index;
        logic        [DSQ_W-1:0]   distance_squared;
        logic        [ROOT_W-1:0]  distance;
    } nps_rsp_t;

    // Tag that travels with each cloud entry through the distance pipeline
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ADDR_W-1:0] idx;
        nps_point_t        pt;
    } nps_tag_t;

endpackage

`default_nettype wire

// ===== src/nps_ram.sv =====
`default_nettype none

module nps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/nps_dist.sv =====
`default_nettype none

module nps_dist
    import nps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire nps_point_t query,
    input  wire nps_tag_t   tag_in,
    output nps_tag_t        tag_out,
    output logic [DSQ_W-1:0] dist_sq
);

    logic signed [COORD_W:0] dx, dy, dz;
    logic        [COORD_W:0] ax, ay, az;

    logic [COORD_W-1:0]   mag_x_reg, mag_y_reg, mag_z_reg;
    logic [2*COORD_W-1:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic [DSQ_W-1:0]     sum_reg;
    nps_tag_t             tag_a_reg, tag_b_reg, tag_c_reg;

    // Take differences and magnitudes
    always_comb
    begin
        dx = {query.x[COORD_W-1], query.x} - {tag_in.pt.x[COORD_W-1], tag_in.pt.x};
        dy = {query.y[COORD_W-1], query.y} - {tag_in.pt.y[COORD_W-1], tag_in.pt.y};
        dz = {query.z[COORD_W-1], query.z} - {tag_in.pt.z[COORD_W-1], tag_in.pt.z};
        ax = dx[COORD_W] ? -dx : dx;
        ay = dy[COORD_W] ? -dy : dy;
        az = dz[COORD_W] ? -dz : dz;
    end

    // Advance tags through the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    // Magnitudes, squares, then the sum
    always_ff @(posedge clk)
    begin
        mag_x_reg <= ax[COORD_W-1:0];
        mag_y_reg <= ay[COORD_W-1:0];
        mag_z_reg <= az[COORD_W-1:0];
        sq_x_reg  <= mag_x_reg * mag_x_reg;
        sq_y_reg  <= mag_y_reg * mag_y_reg;
        sq_z_reg  <= mag_z_reg * mag_z_reg;
        sum_reg   <= {2'b00, sq_x_reg} + {2'b00, sq_y_reg} + {2'b00, sq_z_reg};
    end

    assign tag_out = tag_c_reg;
    assign dist_sq = sum_reg;

endmodule

`default_nettype wire

// ===== src/nps_isqrt.sv =====
`default_nettype none

module nps_isqrt
    import nps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DSQ_W-1:0]  value,
    output logic                   done,
    output logic      [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [DSQ_W-1:0]  val_reg, val_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;

    // One result bit per cycle, two radicand bits brought down each step
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], val_reg[DSQ_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[DSQ_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== src/nearest_point_search.sv =====
`default_nettype none

// Channel   Direction  Handshake          Beat
// req       in         req_valid/stall    nps_req_t: write a point or run a query
// rsp       out        rsp_valid/stall    nps_rsp_t: closest point, one per query
// cfg       in         cfg_we             cfg_data: cloud_size
//
// A query reads one cloud entry per cycle from the store, which has separate
// read and write ports, and streams each entry through the distance pipeline;
// then the 17-step square root unit runs.
// req_stall is high for the whole query; the result sits in an output register
// so the next beat is taken while rsp_stall holds the previous result.
// Reset clears control state and sets cloud_size to 1; stored points are not
// cleared.

module nearest_point_search
    import nps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire nps_req_t          req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output nps_rsp_t               rsp,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_START,
        ST_ROOT,
        ST_WAIT
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    nps_point_t        query_reg, query_next;
    logic              p1_valid_reg, p1_valid_next;
    logic              p1_last_reg, p1_last_next;
    logic [ADDR_W-1:0] p1_idx_reg, p1_idx_next;
    logic [DSQ_W-1:0]  best_d_reg, best_d_next;
    logic [ADDR_W-1:0] best_idx_reg, best_idx_next;
    nps_point_t        best_pt_reg, best_pt_next;
    logic              rsp_valid_reg, rsp_valid_next;
    nps_rsp_t          rsp_reg, rsp_next;

    logic              req_accept;
    logic              ram_we;
    logic              ram_re;
    nps_point_t        ram_wdata;
    nps_point_t        ram_rdata;
    nps_tag_t          dist_in;
    nps_tag_t          dist_out;
    logic [DSQ_W-1:0]  dist_sq;
    logic              better;
    logic              root_done;
    logic [ROOT_W-1:0] root;
    logic [SIZE_W-1:0] count;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign ram_we     = req_accept && (req.op == OP_WRITE);
    assign ram_re     = (state_reg == ST_SCAN);
    assign ram_wdata  = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};

    // Clamp the searched size to one through the store depth
    always_comb
    begin
        count = size_reg;
        if (size_reg == '0)
        begin
            count = SIZE_W'(1);
        end
        else if (size_reg > SIZE_W'(CLOUD_DEPTH))
        begin
            count = SIZE_W'(CLOUD_DEPTH);
        end
    end

    nps_ram #(
        .WIDTH ($bits(nps_point_t)),
        .DEPTH (CLOUD_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req.index[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Join the read data with its tag
    always_comb
    begin
        dist_in.valid = p1_valid_reg;
        dist_in.last  = p1_last_reg;
        dist_in.idx   = p1_idx_reg;
        dist_in.pt    = ram_rdata;
    end

    nps_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_reg),
        .tag_in  (dist_in),
        .tag_out (dist_out),
        .dist_sq (dist_sq)
    );

    nps_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_START),
        .value (best_d_reg),
        .done  (root_done),
        .root  (root)
    );

    // First entry always takes the lead; later ones only when strictly closer
    assign better = dist_out.valid && ((dist_out.idx == '0) || (dist_sq < best_d_reg));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        size_next      = cfg_we ? cfg_data : size_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        query_next     = query_reg;
        p1_valid_next  = ram_re;
        p1_last_next   = ram_re && (addr_reg == last_reg);
        p1_idx_next    = addr_reg;
        best_d_next    = best_d_reg;
        best_idx_next  = best_idx_reg;
        best_pt_next   = best_pt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        if (better)
        begin
            best_d_next   = dist_sq;
            best_idx_next = dist_out.idx;
            best_pt_next  = dist_out.pt;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (req.op == OP_QUERY))
                begin
                    addr_next  = '0;
                    last_next  = ADDR_W'(count - 1'b1);
                    query_next = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (dist_out.valid && dist_out.last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.near_x           = best_pt_reg.x;
                    rsp_next.near_y           = best_pt_reg.y;
                    rsp_next.near_z           = best_pt_reg.z;
                    rsp_next.near_index       = INDEX_W'(best_idx_reg);
                    rsp_next.distance_squared = best_d_reg;
                    rsp_next.distance         = root;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_W'(1);
            p1_valid_reg  <= 1'b0;
            p1_last_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            p1_valid_reg  <= p1_valid_next;
            p1_last_reg   <= p1_last_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        last_reg     <= last_next;
        query_reg    <= query_next;
        p1_idx_reg   <= p1_idx_next;
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        best_pt_reg  <= best_pt_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // A new result is only loaded from the wait state
    a_rsp_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_WAIT))
        else $error("result loaded outside wait state");

    // The store is never written while a query reads it
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("store written during a query");

    // Distance beats only emerge while a query is scanning or draining
    a_dist_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        dist_out.valid |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("distance beat outside a query");

    // The root bounds the squared distance from both sides
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |->
            (({18'd0, rsp_reg.distance} * {18'd0, rsp_reg.distance})
                <= {1'b0, rsp_reg.distance_squared}) &&
            (({18'd0, rsp_reg.distance} + 35'd1) * ({18'd0, rsp_reg.distance} + 35'd1)
                > {1'b0, rsp_reg.distance_squared}))
        else $error("square root out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/nearest_result_check.sv =====
module nearest_result_check
    import nps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_stall,
    input  wire nps_req_t          req,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire nps_rsp_t          rsp,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_data,
    output int                     mismatch_count,
    output int                     results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Shadow of the cloud store and of the size register
    nps_point_t        cloud_copy [CLOUD_DEPTH];
    logic [SIZE_W-1:0] size_copy;
    nps_rsp_t          nearest_due [$];

    // Exact squared Euclidean distance between two points
    function automatic logic [DSQ_W-1:0] squared_gap(nps_point_t a, nps_point_t b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(a.x)) - longint'($signed(b.x));
        dy = longint'($signed(a.y)) - longint'($signed(b.y));
        dz = longint'($signed(a.z)) - longint'($signed(b.z));
        return DSQ_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Floor square root, one result bit per step from the top
    function automatic logic [ROOT_W-1:0] floor_root(logic [DSQ_W-1:0] n);
        longint unsigned root;
        longint unsigned trial;
        int              b;
        root = 0;
        for (b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return ROOT_W'(root);
    endfunction

    // Scan the searched entries; only a strictly closer entry takes over
    function automatic nps_rsp_t predict_nearest(nps_point_t probe);
        int               reach;
        int               best_i;
        int               i;
        logic [DSQ_W-1:0] best_d;
        logic [DSQ_W-1:0] d;
        nps_rsp_t         hit;
        reach = (size_copy == 0) ? 1 :
                ((size_copy > CLOUD_DEPTH) ? CLOUD_DEPTH : int'(size_copy));
        best_i = 0;
        best_d = squared_gap(probe, cloud_copy[0]);
        for (i = 1; i < reach; i++)
        begin
            d = squared_gap(probe, cloud_copy[i]);
            if (d < best_d)
            begin
                best_d = d;
                best_i = i;
            end
        end
        hit.near_x           = cloud_copy[best_i].x;
        hit.near_y           = cloud_copy[best_i].y;
        hit.near_z           = cloud_copy[best_i].z;
        hit.near_index       = INDEX_W'(best_i);
        hit.distance_squared = best_d;
        hit.distance         = floor_root(best_d);
        return hit;
    endfunction

    initial
    begin
        mismatch_count = 0;
        results_due    = 0;
        size_copy      = SIZE_W'(1);
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        nps_rsp_t   want;
        nps_point_t pt;
        if (!rst_n)
        begin
            size_copy = SIZE_W'(1);
            nearest_due.delete();
        end
        else
        begin
            // track the size register
            if (cfg_we)
                size_copy = cfg_data;

            // compare a result beat with the oldest expectation
            if (rsp_valid && !rsp_stall)
            begin
                if (nearest_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: result beat with nothing expected", $time);
                        $display("  actual   x=%0d y=%0d z=%0d idx=%0d dsq=%0d d=%0d",
                                 rsp.near_x, rsp.near_y, rsp.near_z, rsp.near_index,
                                 rsp.distance_squared, rsp.distance);
                    end
                end
                else
                begin
                    want = nearest_due.pop_front();
                    if (want.near_x !== rsp.near_x || want.near_y !== rsp.near_y ||
                        want.near_z !== rsp.near_z || want.near_index !== rsp.near_index ||
                        want.distance_squared !== rsp.distance_squared ||
                        want.distance !== rsp.distance)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: nearest mismatch", $time);
                            $display("  expected x=%0d y=%0d z=%0d idx=%0d dsq=%0d d=%0d",
                                     want.near_x, want.near_y, want.near_z, want.near_index,
                                     want.distance_squared, want.distance);
                            $display("  actual   x=%0d y=%0d z=%0d idx=%0d dsq=%0d d=%0d",
                                     rsp.near_x, rsp.near_y, rsp.near_z, rsp.near_index,
                                     rsp.distance_squared, rsp.distance);
                        end
                    end
                end
            end

            // store a point, or queue the answer to a query
            if (req_valid && !req_stall)
            begin
                pt.x = req.coord_x;
                pt.y = req.coord_y;
                pt.z = req.coord_z;
                if (req.op == OP_WRITE)
                    cloud_copy[req.index] = pt;
                else
                    nearest_due.push_back(predict_nearest(pt));
            end
        end
        results_due = nearest_due.size();
    end

endmodule

// ===== tb/tb_nearest_point_search.sv =====
module tb_nearest_point_search
    import nps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 500;
    localparam int FILL_DEPTH     = 64;
    localparam int CALM_TAIL      = 60;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 8000;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    nps_req_t          req;
    logic              rsp_valid;
    logic              rsp_stall;
    nps_rsp_t          rsp;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_data;
    int                mismatch_count;
    int                results_due;
    bit                calm;

    nearest_point_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    nearest_result_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stall the result channel in short random bursts
    initial
    begin : result_stall
        int left;
        left = 0;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (left > 0)
                left--;
            else if (!calm && $urandom_range(0, 4) == 0)
                left = $urandom_range(1, 3);
            rsp_stall <= (left > 0);
        end
    end

    // End the run when no beat moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic nps_point_t make_point(logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y,
                                              logic signed [COORD_W-1:0] z);
        nps_point_t pt;
        pt.x = x;
        pt.y = y;
        pt.z = z;
        return pt;
    endfunction

    // Clustered coordinates mostly sit near the origin so ties and exact hits are common
    function automatic logic signed [COORD_W-1:0] pick_coord(bit clustered);
        logic signed [COORD_W-1:0] v;
        int unsigned               roll;
        roll = $urandom_range(0, 9);
        if (clustered ? (roll < 8) : (roll == 9))
        begin
            v = COORD_W'(int'($urandom_range(0, 6)) - 3);
        end
        else if (!clustered && roll >= 7)
        begin
            case ($urandom_range(0, 6))
                0:       v = 16'sh8000;
                1:       v = 16'sh8001;
                2:       v = -16'sd1;
                3:       v = 16'sd0;
                4:       v = 16'sd1;
                5:       v = 16'sh7FFE;
                default: v = 16'sh7FFF;
            endcase
        end
        else
            v = COORD_W'($urandom);
        return v;
    endfunction

    function automatic nps_point_t pick_point(bit clustered);
        return make_point(pick_coord(clustered), pick_coord(clustered), pick_coord(clustered));
    endfunction

    // Present one beat and hold it until accepted
    task automatic send_beat(input nps_req_t beat);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic write_point(input logic [INDEX_W-1:0] slot, input nps_point_t pt);
        nps_req_t beat;
        beat.op      = OP_WRITE;
        beat.index   = slot;
        beat.coord_x = pt.x;
        beat.coord_y = pt.y;
        beat.coord_z = pt.z;
        send_beat(beat);
    endtask

    // The index field of a query is don't-care, so fill it with noise
    task automatic query_point(input nps_point_t pt);
        nps_req_t beat;
        beat.op      = OP_QUERY;
        beat.index   = INDEX_W'($urandom);
        beat.coord_x = pt.x;
        beat.coord_y = pt.y;
        beat.coord_z = pt.z;
        send_beat(beat);
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle
    task automatic wait_drained(input int settle);
        req_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_cloud_size(input logic [SIZE_W-1:0] value);
        wait_drained(SETTLE_CYCLES);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        nps_point_t  far_hi;
        nps_point_t  far_lo;
        nps_point_t  twin;
        int          i;
        int          span;
        int          reach;
        int          phase_len;
        int          roll;
        int          random_sent;
        bit          clustered;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_data  <= '0;
        calm       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Size one out of reset: opposite corners and an exact hit
        far_hi = make_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        far_lo = make_point(16'sh8000, 16'sh8000, 16'sh8000);
        write_point(10'd0, far_hi);
        query_point(far_lo);
        query_point(far_hi);
        write_point(10'd0, far_lo);
        query_point(far_hi);
        query_point(make_point(16'sd0, 16'sd0, 16'sd0));

        // Size zero still searches the first entry
        set_cloud_size(11'd0);
        write_point(10'd1023, far_hi);
        query_point(make_point(16'sd1, 16'sd2, 16'sd3));

        // Equal distances: the lowest index has to win
        twin = make_point(16'sd5000, 16'sd5000, 16'sd5000);
        write_point(10'd0, make_point(16'sd10, 16'sd0, 16'sd0));
        write_point(10'd1, twin);
        write_point(10'd2, make_point(-16'sd10, 16'sd0, 16'sd0));
        write_point(10'd3, twin);
        set_cloud_size(11'd4);
        query_point(make_point(16'sd0, 16'sd0, 16'sd0));
        query_point(make_point(16'sd0, 16'sd3, 16'sd0));
        query_point(make_point(16'sd5000, 16'sd5000, 16'sd5001));

        // Fill the low entries so every size used below reads written entries only
        for (i = 0; i < FILL_DEPTH; i++)
            write_point(INDEX_W'(i), pick_point(1'b0));

        // Random phases: a new size each, mostly small clouds
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                span = FILL_DEPTH;
            else if (roll == 1)
                span = $urandom_range(0, 1);
            else
                span = $urandom_range(2, FILL_DEPTH);
            set_cloud_size(SIZE_W'(span));
            reach     = (span == 0) ? 1 : ((span > CLOUD_DEPTH) ? CLOUD_DEPTH : span);
            phase_len = (roll == 0) ? $urandom_range(4, 10) : $urandom_range(20, 50);
            clustered = ($urandom_range(0, 2) == 0);
            calm      = (RANDOM_ITEMS - random_sent <= CALM_TAIL) || ($urandom_range(0, 4) == 0);
            repeat (phase_len)
            begin
                if ($urandom_range(0, 1) == 1)
                    query_point(pick_point(clustered));
                else if ($urandom_range(0, 7) != 0)
                    write_point(INDEX_W'($urandom_range(0, reach - 1)), pick_point(clustered));
                else
                    write_point(INDEX_W'($urandom), pick_point(clustered));
                random_sent++;
            end
        end

        wait_drained(DRAIN_CYCLES);
        if (mismatch_count == 0 && results_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
